@@ rtl/iflt_pkg.sv @@
// ----------------------------------------------------------------------------
// iflt_pkg
// Shared constants, codes and control types of the interval floor lookup table.
// ----------------------------------------------------------------------------
package iflt_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int LEN_BITS  = 17;
    localparam int FUNC_BITS = 2;
    localparam int STAT_BITS = 2;

    // operation codes; the unused code behaves as a lookup
    localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STAT_BITS-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_COVERED = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_BITS-1:0] STAT_MISS    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;    // latch the input word, restart the scan
        logic scan;    // read the entry at the scan pointer, advance
        logic commit;  // apply the table update, load the result register
    } iflt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan pointer sits on the last entry
        logic out_free;   // result register can take a new word
    } iflt_sts_t;

endpackage

@@ rtl/iflt_ctrl.sv @@
// ----------------------------------------------------------------------------
// iflt_ctrl
// Sequencer: accept one word, sweep the table, then commit the result.
// ----------------------------------------------------------------------------
module iflt_ctrl
    import iflt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  iflt_sts_t sts,
    output iflt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.load   = s_valid && s_ready;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_DECIDE) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            // last read word is evaluated here
            ST_LAST: begin
                state_next = ST_DECIDE;
            end
            // hold until the result register frees up
            ST_DECIDE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.load)
        else $error("word accepted while a sweep is in progress");

    a_load_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.scan)
        else $error("accepted word did not start a sweep");

    a_commit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_ready)
        else $error("controller not idle after commit");

endmodule

@@ rtl/iflt_datapath.sv @@
// ----------------------------------------------------------------------------
// iflt_datapath
// Entry memory, valid bits, sweep tracking of floor/match/free slot, and the
// result register.
// ----------------------------------------------------------------------------
module iflt_datapath
    import iflt_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iflt_cmd_t              cmd,
    output iflt_sts_t              sts,
    input  logic [FUNC_BITS-1:0]   s_func,
    input  logic [OFFSET_BITS-1:0] s_offset,
    input  logic [LEN_BITS-1:0]    s_length,
    input  logic [HANDLE_BITS-1:0] s_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STAT_BITS-1:0]   m_status,
    output logic                   m_found,
    output logic [OFFSET_BITS-1:0] m_start_out,
    output logic [HANDLE_BITS-1:0] m_handle_out
);

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CMP_BITS = OFFSET_BITS + LEN_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    // entry storage
    logic [OFFSET_BITS-1:0] mem_start  [ENTRIES];
    logic [LEN_BITS-1:0]    mem_length [ENTRIES];
    logic [HANDLE_BITS-1:0] mem_handle [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;

    // latched request
    logic [FUNC_BITS-1:0]   func_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;

    // sweep
    logic [IDX_BITS-1:0]    cnt_reg;
    logic                   rd_vld_reg;
    logic [IDX_BITS-1:0]    rd_idx_reg;
    logic [OFFSET_BITS-1:0] rd_start_reg;
    logic [LEN_BITS-1:0]    rd_len_reg;
    logic [HANDLE_BITS-1:0] rd_hnd_reg;

    logic                   best_vld_reg;
    logic [OFFSET_BITS-1:0] best_start_reg;
    logic [LEN_BITS-1:0]    best_len_reg;
    logic [HANDLE_BITS-1:0] best_hnd_reg;
    logic [IDX_BITS-1:0]    best_idx_reg;
    logic                   same_vld_reg;
    logic [IDX_BITS-1:0]    same_idx_reg;
    logic                   free_vld_reg;
    logic [IDX_BITS-1:0]    free_idx_reg;

    // result register
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [STAT_BITS-1:0]   status_reg;
    logic                   found_reg;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic                   cur_vld;
    logic                   is_better;
    logic                   is_same;
    logic                   is_free;
    logic [OFFSET_BITS-1:0] diff;
    logic                   covers;

    logic                   wr_en;
    logic                   set_vld;
    logic                   clr_vld;
    logic [IDX_BITS-1:0]    wr_idx;
    logic [STAT_BITS-1:0]   res_status;
    logic                   res_found;
    logic [OFFSET_BITS-1:0] res_start;
    logic [HANDLE_BITS-1:0] res_handle;

    assign sts.scan_last = (cnt_reg == LAST_IDX);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // evaluate the word read in the previous cycle
    assign cur_vld   = valid_reg[rd_idx_reg];
    assign is_better = rd_vld_reg && cur_vld && (rd_start_reg <= off_reg)
                       && (!best_vld_reg || (rd_start_reg > best_start_reg));
    assign is_same   = rd_vld_reg && cur_vld && (rd_start_reg == off_reg)
                       && !same_vld_reg;
    assign is_free   = rd_vld_reg && !cur_vld && !free_vld_reg;

    // covered when offset - start < length; never forms start + length
    assign diff   = off_reg - best_start_reg;
    assign covers = best_vld_reg && (CMP_BITS'(diff) < CMP_BITS'(best_len_reg));

    always_comb begin
        wr_en      = 1'b0;
        set_vld    = 1'b0;
        clr_vld    = 1'b0;
        wr_idx     = free_idx_reg;
        res_status = STAT_OK;
        res_found  = 1'b1;
        res_start  = best_start_reg;
        res_handle = best_hnd_reg;
        if (func_reg == FUNC_INSERT) begin
            priority if (covers) begin
                res_status = STAT_COVERED;
            end else if (same_vld_reg) begin
                // zero-length entry at the same start: overwrite in place
                wr_en      = 1'b1;
                wr_idx     = same_idx_reg;
                res_start  = off_reg;
                res_handle = hnd_reg;
            end else if (free_vld_reg) begin
                wr_en      = 1'b1;
                set_vld    = 1'b1;
                res_start  = off_reg;
                res_handle = hnd_reg;
            end else begin
                res_status = STAT_FULL;
                res_found  = 1'b0;
                res_start  = '0;
                res_handle = '0;
            end
        end else if (!covers) begin
            res_status = STAT_MISS;
            res_found  = 1'b0;
            res_start  = '0;
            res_handle = '0;
        end else begin
            clr_vld = (func_reg == FUNC_REMOVE);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit && set_vld) begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cmd.commit && clr_vld) begin
            valid_next[best_idx_reg] = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // memory: one read port for the sweep, one write port for commit
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_start_reg <= mem_start[cnt_reg];
            rd_len_reg   <= mem_length[cnt_reg];
            rd_hnd_reg   <= mem_handle[cnt_reg];
        end
        if (cmd.commit && wr_en) begin
            mem_start[wr_idx]  <= off_reg;
            mem_length[wr_idx] <= len_reg;
            mem_handle[wr_idx] <= hnd_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            cnt_reg      <= '0;
            best_vld_reg <= 1'b0;
            same_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= cmd.scan;
            if (cmd.load) begin
                cnt_reg      <= '0;
                best_vld_reg <= 1'b0;
                same_vld_reg <= 1'b0;
                free_vld_reg <= 1'b0;
            end else begin
                if (cmd.scan && !sts.scan_last) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (is_better) begin
                    best_vld_reg <= 1'b1;
                end
                if (is_same) begin
                    same_vld_reg <= 1'b1;
                end
                if (is_free) begin
                    free_vld_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            off_reg  <= s_offset;
            len_reg  <= s_length;
            hnd_reg  <= s_handle;
        end
        rd_idx_reg <= cnt_reg;
        if (is_better) begin
            best_start_reg <= rd_start_reg;
            best_len_reg   <= rd_len_reg;
            best_hnd_reg   <= rd_hnd_reg;
            best_idx_reg   <= rd_idx_reg;
        end
        if (is_same) begin
            same_idx_reg <= rd_idx_reg;
        end
        if (is_free) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit) begin
            status_reg <= res_status;
            found_reg  <= res_found;
            start_reg  <= res_start;
            handle_reg <= res_handle;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_found      = found_reg;
    assign m_start_out  = start_reg;
    assign m_handle_out = handle_reg;

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit overwrote an untaken result word");

    a_valid_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(valid_reg))
        else $error("valid bits changed outside commit");

    a_insert_fills_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && set_vld) |-> free_vld_reg && !valid_reg[free_idx_reg])
        else $error("insert targeted an occupied slot");

    a_load_resets_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cnt_reg == '0) && !best_vld_reg && !free_vld_reg)
        else $error("sweep state not cleared on accept");

endmodule

@@ rtl/interval_floor_lookup_table.sv @@
// ----------------------------------------------------------------------------
// interval_floor_lookup_table
// Table of ranges (start, length, handle) with insert, remove and floor lookup.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | s_valid s_ready s_func s_offset         | in
//           | s_length s_handle                       |
//   result  | m_valid m_ready m_status m_found        | out
//           | m_start_out m_handle_out                |
//
// The entry memory has a single read port and is swept one entry per
// cycle; the last read is then evaluated, and the result is committed once
// the result register is free. Words are handled one at a time. Reset
// clears the valid bits at once; no clearing pass is needed. A stalled
// result word holds in the output register while the next request is
// accepted; that request then waits at commit until the word is taken.
// ----------------------------------------------------------------------------
module interval_floor_lookup_table
    import iflt_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FUNC_BITS-1:0]   s_func,
    input  logic [OFFSET_BITS-1:0] s_offset,
    input  logic [LEN_BITS-1:0]    s_length,
    input  logic [HANDLE_BITS-1:0] s_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STAT_BITS-1:0]   m_status,
    output logic                   m_found,
    output logic [OFFSET_BITS-1:0] m_start_out,
    output logic [HANDLE_BITS-1:0] m_handle_out
);

    iflt_cmd_t cmd;
    iflt_sts_t sts;

    iflt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iflt_datapath #(
        .ENTRIES     (ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_func       (s_func),
        .s_offset     (s_offset),
        .s_length     (s_length),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_start_out  (m_start_out),
        .m_handle_out (m_handle_out)
    );

endmodule

@@ dv/interval_floor_lookup_table_tb.sv @@
// ----------------------------------------------------------------------------
// interval_floor_lookup_table_tb
// Self-checking bench for the interval floor lookup table. A short directed
// opening covers the corner cases: empty map, query below every start,
// zero-length ranges, same-start overwrite, the spare func code and the top
// of the offset space. Phases of fill, balanced and drain traffic follow,
// with random gaps on the request side and random stalls on the result side.
// A shadow copy of the range map predicts each result word.
// ----------------------------------------------------------------------------
module interval_floor_lookup_table_tb;
    import iflt_pkg::*;

    localparam int NUM_ENTRIES  = ENTRIES_DEF;
    localparam int OFF_W        = OFFSET_BITS_DEF;
    localparam int HND_W        = HANDLE_BITS_DEF;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_CYCLES   = 1000000;
    localparam int DRAIN_CYCLES = 3 * NUM_ENTRIES + 20;

    // spare code, handled as a lookup
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE = 2'd3;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_e;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [OFF_W-1:0]     offset;
        logic [LEN_BITS-1:0]  length;
        logic [HND_W-1:0]     handle;
    } range_req_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic                 found;
        logic [OFF_W-1:0]     start;
        logic [HND_W-1:0]     handle;
    } range_rsp_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [FUNC_BITS-1:0] s_func;
    logic [OFF_W-1:0]     s_offset;
    logic [LEN_BITS-1:0]  s_length;
    logic [HND_W-1:0]     s_handle;
    logic                 m_valid;
    logic                 m_ready;
    logic [STAT_BITS-1:0] m_status;
    logic                 m_found;
    logic [OFF_W-1:0]     m_start_out;
    logic [HND_W-1:0]     m_handle_out;

    // shadow of the range map
    logic                map_valid [NUM_ENTRIES];
    logic [OFF_W-1:0]    map_start [NUM_ENTRIES];
    logic [LEN_BITS-1:0] map_len   [NUM_ENTRIES];
    logic [HND_W-1:0]    map_hnd   [NUM_ENTRIES];

    range_req_t       req_backlog[$];
    range_rsp_t       rsp_due[$];
    logic [OFF_W-1:0] used_starts[$];

    logic   req_fire;
    int     gap_left;
    int     send_calm;
    int     stall_left;
    int     rdy_calm;
    int     err_count;
    longint cycle_count;

    interval_floor_lookup_table uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_offset     (s_offset),
        .s_length     (s_length),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_start_out  (m_start_out),
        .m_handle_out (m_handle_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // slot of the range covering off: greatest start at or below off, and
    // off must lie inside it; -1 when none
    function automatic int covering_slot(logic [OFF_W-1:0] off);
        int best = -1;
        logic [OFF_W-1:0] delta;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (map_valid[i] && map_start[i] <= off &&
                (best < 0 || map_start[i] > map_start[best]))
                best = i;
        end
        if (best >= 0) begin
            delta = off - map_start[best];
            if (delta < OFF_W'(map_len[best]))
                return best;
        end
        return -1;
    endfunction

    // apply one word to the shadow map and return the result it produces
    function automatic range_rsp_t run_range_op(range_req_t r);
        range_rsp_t res;
        int hit;
        int slot = -1;
        hit = covering_slot(r.offset);
        res.status = STAT_MISS;
        res.found  = 1'b0;
        res.start  = '0;
        res.handle = '0;
        if (r.func == FUNC_INSERT) begin
            if (hit >= 0) begin
                res.status = STAT_COVERED;
                res.found  = 1'b1;
                res.start  = map_start[hit];
                res.handle = map_hnd[hit];
                return res;
            end
            // a zero-length range at the same start is overwritten in place
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (slot < 0 && map_valid[i] && map_start[i] == r.offset)
                    slot = i;
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (slot < 0 && !map_valid[i])
                    slot = i;
            end
            if (slot < 0) begin
                res.status = STAT_FULL;
                return res;
            end
            map_valid[slot] = 1'b1;
            map_start[slot] = r.offset;
            map_len[slot]   = r.length;
            map_hnd[slot]   = r.handle;
            res.status = STAT_OK;
            res.found  = 1'b1;
            res.start  = r.offset;
            res.handle = r.handle;
            return res;
        end
        if (hit < 0)
            return res;
        if (r.func == FUNC_REMOVE)
            map_valid[hit] = 1'b0;
        res.status = STAT_OK;
        res.found  = 1'b1;
        res.start  = map_start[hit];
        res.handle = map_hnd[hit];
        return res;
    endfunction

    task automatic check_field(string name, logic [OFF_W-1:0] want,
                               logic [OFF_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic add_req(logic [FUNC_BITS-1:0] func, logic [OFF_W-1:0] off,
                           logic [LEN_BITS-1:0] len, logic [HND_W-1:0] hnd);
        range_req_t q;
        q.func   = func;
        q.offset = off;
        q.length = len;
        q.handle = hnd;
        req_backlog.push_back(q);
        if (func == FUNC_INSERT) begin
            used_starts.push_back(off);
            if (used_starts.size() > 128)
                void'(used_starts.pop_front());
        end
    endtask

    task automatic add_random_req(traffic_mix_e mix);
        int r;
        logic [FUNC_BITS-1:0] func;
        logic [OFF_W-1:0] off;
        logic [LEN_BITS-1:0] len;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                func = (r < 80) ? FUNC_INSERT : (r < 88) ? FUNC_REMOVE :
                       (r < 98) ? FUNC_LOOKUP : FUNC_SPARE;
            end
            MIX_BALANCED: begin
                func = (r < 35) ? FUNC_INSERT : (r < 60) ? FUNC_REMOVE :
                       (r < 97) ? FUNC_LOOKUP : FUNC_SPARE;
            end
            default: begin
                func = (r < 10) ? FUNC_INSERT : (r < 70) ? FUNC_REMOVE :
                       (r < 97) ? FUNC_LOOKUP : FUNC_SPARE;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 8)
            off = $urandom();
        else if (r < 14)
            off = 32'hFFFF_C000 + $urandom_range(0, 16383);
        else if (used_starts.size() > 0 && (func != FUNC_INSERT || r < 40))
            // land near a known start, now and then just below it
            off = used_starts[$urandom_range(0, used_starts.size() - 1)] +
                  $urandom_range(0, 40) - 2;
        else
            off = 32'h4000_0000 + $urandom_range(0, 16383);
        r = $urandom_range(0, 99);
        if (r < 4)
            len = '0;
        else if (r < 7)
            len = LEN_BITS'($urandom_range(0, 131071));
        else if (r < 9)
            len = 17'd65536;
        else
            len = LEN_BITS'($urandom_range(1, 48));
        add_req(func, off, len, HND_W'($urandom_range(0, 65535)));
    endtask

    // request driver
    always @(negedge aclk) begin
        range_req_t nxt;
        int r;
        if (aresetn && !(s_valid && !req_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                nxt = req_backlog.pop_front();
                s_valid  <= 1'b1;
                s_func   <= nxt.func;
                s_offset <= nxt.offset;
                s_length <= nxt.length;
                s_handle <= nxt.handle;
                if (send_calm > 0) begin
                    send_calm--;
                    gap_left = 0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        send_calm = $urandom_range(10, 40);
                    if (r < 60)
                        gap_left = 0;
                    else if (r < 92)
                        gap_left = $urandom_range(1, 4);
                    else
                        gap_left = $urandom_range(10, 90);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        int r;
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rdy_calm > 0) begin
                rdy_calm--;
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    rdy_calm = $urandom_range(200, 800);
                else if (r < 10)
                    stall_left = $urandom_range(0, 3);
                else if (r < 12)
                    stall_left = $urandom_range(20, 150);
                m_ready <= !(r >= 2 && r < 12);
            end
        end
    end

    // monitor: check result words, predict accepted request words
    always @(posedge aclk) begin
        range_rsp_t want;
        range_req_t taken;
        if (!aresetn) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (rsp_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word, status %0d start %0h handle %0h",
                             $time, m_status, m_start_out, m_handle_out);
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", OFF_W'(want.status), OFF_W'(m_status));
                    check_field("found", OFF_W'(want.found), OFF_W'(m_found));
                    check_field("start_out", want.start, m_start_out);
                    check_field("handle_out", OFF_W'(want.handle), OFF_W'(m_handle_out));
                end
            end
            if (s_valid && s_ready) begin
                taken = '{s_func, s_offset, s_length, s_handle};
                rsp_due.push_back(run_range_op(taken));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        traffic_mix_e plan [8];
        plan = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL,
                 MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL};
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_func      = FUNC_INSERT;
        s_offset    = '0;
        s_length    = '0;
        s_handle    = '0;
        m_ready     = 1'b0;
        gap_left    = 0;
        send_calm   = 0;
        stall_left  = 0;
        rdy_calm    = 0;
        err_count   = 0;
        cycle_count = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            map_valid[i] = 1'b0;
            map_start[i] = '0;
            map_len[i]   = '0;
            map_hnd[i]   = '0;
        end

        // empty map
        add_req(FUNC_LOOKUP, 32'h0000_0000, 17'd1, 16'h0000);
        add_req(FUNC_REMOVE, 32'hFFFF_FFFF, 17'd1, 16'h0000);
        add_req(FUNC_INSERT, 32'h0000_1000, 17'd16, 16'hFFFF);
        // below every start, edges of the range, one past the end
        add_req(FUNC_LOOKUP, 32'h0000_0FFF, 17'd0, 16'h0000);
        add_req(FUNC_LOOKUP, 32'h0000_1000, 17'd0, 16'h0000);
        add_req(FUNC_LOOKUP, 32'h0000_100F, 17'd0, 16'h0000);
        add_req(FUNC_LOOKUP, 32'h0000_1010, 17'd0, 16'h0000);
        add_req(FUNC_INSERT, 32'h0000_1008, 17'd4, 16'h5555);
        // zero-length range, then overwrite at the same start
        add_req(FUNC_INSERT, 32'h0000_2000, 17'd0, 16'h1234);
        add_req(FUNC_LOOKUP, 32'h0000_2000, 17'd0, 16'h0000);
        add_req(FUNC_INSERT, 32'h0000_2000, 17'd5, 16'h4321);
        add_req(FUNC_SPARE,  32'h0000_2004, 17'd0, 16'h0000);
        // top of the offset space with the widest length
        add_req(FUNC_INSERT, 32'hFFFF_FFF0, 17'h1FFFF, 16'h0000);
        add_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 17'd0, 16'h0000);
        add_req(FUNC_INSERT, 32'h0000_0000, 17'd65536, 16'hABCD);
        add_req(FUNC_LOOKUP, 32'h0000_0FFF, 17'd0, 16'h0000);
        add_req(FUNC_REMOVE, 32'h0000_2002, 17'd0, 16'h0000);
        add_req(FUNC_LOOKUP, 32'h0000_2002, 17'd0, 16'h0000);
        add_req(FUNC_REMOVE, 32'h0000_3000, 17'd0, 16'h0000);
        add_req(FUNC_REMOVE, 32'h0000_1005, 17'd0, 16'h0000);
        add_req(FUNC_REMOVE, 32'h0000_8000, 17'd0, 16'h0000);
        add_req(FUNC_INSERT, 32'h7FFF_FFFF, 17'd1, 16'h8000);
        add_req(FUNC_LOOKUP, 32'h7FFF_FFFF, 17'd0, 16'h0000);

        foreach (plan[p]) begin
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_random_req(plan[p]);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() > 0 || s_valid)
            @(posedge aclk);
        while (rsp_due.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/iflt_pkg.sv
rtl/iflt_ctrl.sv
rtl/iflt_datapath.sv
rtl/interval_floor_lookup_table.sv
dv/interval_floor_lookup_table_tb.sv
